>>> design/pc_value_table_decoder_unit_assert.svh
// Assertion macros shared by the pc-value table decoder RTL.
// Included by the top level; no other dependencies.
`ifndef PC_VALUE_TABLE_DECODER_UNIT_ASSERT_SVH
`define PC_VALUE_TABLE_DECODER_UNIT_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define PCVT_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define PCVT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pcvt_pkg.sv
// Shared types and constants for the pc-value table decoder.
// No dependencies; used by every module of the block.
package pcvt_pkg;

    // Varint coding constants.
    localparam int          GROUP_BITS  = 7;
    localparam int          CONT_BIT    = 7;
    localparam logic [2:0]  MAX_GROUPS  = 3'd5;
    localparam logic [31:0] VALUE_INIT  = 32'hFFFF_FFFF;
    localparam logic [3:0]  SCALE_INIT  = 4'd1;

    // Queue sizes.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

    // Input word: one table byte with its framing marks.
    typedef struct packed {
        logic [7:0] table_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic signed [31:0] entry_value;
        logic        [31:0] start_pc;
        logic        [31:0] end_pc;
        logic               finished;
    } t_out_word;

    // Operation carried from the front to the back.
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_VALUE = 2'd1,
        CMD_PC    = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic        restart;
        t_cmd_kind   kind;
        logic [31:0] delta;
        logic        finish_after;
    } t_cmd;

    // Back-end status seen by the top level.
    typedef struct packed {
        logic second;
        logic outq_full;
    } t_back_status;

endpackage

>>> design/pcvt_front.sv
// Front end: gathers varint groups and issues a command for each completed field, restart or end of table.
// Depends on pcvt_pkg.
module pcvt_front
    import pcvt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_word i_word,
    input  logic     i_cmd_full,
    output logic     o_cmd_push,
    output t_cmd     o_cmd
);

    logic        r_in_pc_phase, n_in_pc_phase;
    logic [31:0] r_accum,       n_accum;
    logic [2:0]  r_shift,       n_shift;
    logic        r_first_pair,  n_first_pair;
    logic        r_done,        n_done;

    logic        e_phase, e_first_pair, e_done;
    logic [31:0] e_accum;
    logic [2:0]  e_shift;
    logic [4:0]  sh_amt;
    logic [31:0] group_val;
    logic        accept;

    assign accept = i_push && !i_cmd_full;

    // Decode one byte against the table state (restart applied first).
    always_comb begin
        e_phase      = i_word.first_byte ? 1'b0  : r_in_pc_phase;
        e_accum      = i_word.first_byte ? '0    : r_accum;
        e_shift      = i_word.first_byte ? '0    : r_shift;
        e_first_pair = i_word.first_byte ? 1'b1  : r_first_pair;
        e_done       = i_word.first_byte ? 1'b0  : r_done;

        sh_amt    = {2'b00, e_shift} * 5'(GROUP_BITS);
        group_val = {25'd0, i_word.table_byte[GROUP_BITS-1:0]} << sh_amt;

        n_in_pc_phase = e_phase;
        n_accum       = e_accum;
        n_shift       = e_shift;
        n_first_pair  = e_first_pair;
        n_done        = e_done;

        o_cmd.restart      = i_word.first_byte;
        o_cmd.kind         = CMD_NONE;
        o_cmd.delta        = '0;
        o_cmd.finish_after = 1'b0;

        if (!e_done) begin
            if (e_shift < MAX_GROUPS) begin
                n_accum = e_accum | group_val;
                n_shift = e_shift + 3'd1;
            end
            // Last group of a varint closes a field.
            if (!i_word.table_byte[CONT_BIT]) begin
                o_cmd.delta = n_accum;
                n_accum     = '0;
                n_shift     = '0;
                if (!e_phase) begin
                    if (o_cmd.delta == '0 && !e_first_pair) begin
                        n_done             = 1'b1;
                        o_cmd.finish_after = 1'b1;
                    end else begin
                        o_cmd.kind    = CMD_VALUE;
                        n_first_pair  = 1'b0;
                        n_in_pc_phase = 1'b1;
                    end
                end else begin
                    o_cmd.kind    = CMD_PC;
                    n_in_pc_phase = 1'b0;
                end
            end
            // End of table closes it unless a zero delta already did.
            if (i_word.last_byte && !n_done) begin
                n_done             = 1'b1;
                o_cmd.finish_after = 1'b1;
            end
        end

        o_cmd_push = accept && (o_cmd.restart || o_cmd.kind != CMD_NONE
                                || o_cmd.finish_after);
    end

    // Table state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pc_phase <= 1'b0;
            r_accum       <= '0;
            r_shift       <= '0;
            r_first_pair  <= 1'b1;
            r_done        <= 1'b0;
        end else if (accept) begin
            r_in_pc_phase <= n_in_pc_phase;
            r_accum       <= n_accum;
            r_shift       <= n_shift;
            r_first_pair  <= n_first_pair;
            r_done        <= n_done;
        end
    end

endmodule

>>> design/pcvt_cmd_queue.sv
// Short command queue between the front and the back end.
// Depends on pcvt_pkg.
module pcvt_cmd_queue
    import pcvt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp, r_rp;
    logic [CMDQ_AW:0]   r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Occupancy after this cycle's push and pop.
    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

>>> design/pcvt_back.sv
// Back end: applies value and pc deltas and queues the result words.
// Depends on pcvt_pkg.
module pcvt_back
    import pcvt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [3:0]   i_pc_scale,
    input  logic         i_cmd_empty,
    input  t_cmd         i_cmd,
    output logic         o_cmd_pop,
    output logic         o_empty,
    input  logic         i_pop,
    output t_out_word    o_result,
    output t_back_status o_status
);

    logic [31:0] r_value, n_value;
    logic [31:0] r_pc,    n_pc;
    logic        r_second, n_second;

    t_out_word          r_oq [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_wp, r_rp;
    logic [OUTQ_AW:0]   r_cnt, n_cnt;
    logic               oq_full, oq_pop;

    logic [31:0] e_value, e_pc, prod, zig, end_pc;
    logic        need_wr, step, wr;
    t_out_word   wr_data;

    assign oq_full = (r_cnt == (OUTQ_AW+1)'(OUTQ_DEPTH));
    assign oq_pop  = i_pop && !o_empty;
    assign o_empty = (r_cnt == '0);
    assign o_result = r_oq[r_rp];
    assign o_status.second    = r_second;
    assign o_status.outq_full = oq_full;

    // Execute the head command; a pc entry that also ends the table
    // takes a second step for the finished word.
    always_comb begin
        e_value = i_cmd.restart ? VALUE_INIT : r_value;
        e_pc    = i_cmd.restart ? '0 : r_pc;
        prod    = i_cmd.delta * {28'd0, i_pc_scale};
        zig     = (i_cmd.delta >> 1) ^ {32{i_cmd.delta[0]}};
        end_pc  = e_pc + prod;

        n_value  = r_value;
        n_pc     = r_pc;
        n_second = r_second;
        need_wr  = 1'b0;
        o_cmd_pop = 1'b0;

        wr_data.entry_value = r_value;
        wr_data.start_pc    = r_pc;
        wr_data.end_pc      = r_pc;
        wr_data.finished    = 1'b1;

        if (r_second) begin
            need_wr = 1'b1;
        end else begin
            n_value = e_value;
            n_pc    = e_pc;
            case (i_cmd.kind)
                CMD_VALUE: begin
                    n_value = e_value + zig;
                    need_wr = i_cmd.finish_after;
                    wr_data.entry_value = n_value;
                    wr_data.start_pc    = e_pc;
                    wr_data.end_pc      = e_pc;
                end
                CMD_PC: begin
                    n_pc    = end_pc;
                    need_wr = 1'b1;
                    wr_data.entry_value = e_value;
                    wr_data.start_pc    = e_pc;
                    wr_data.end_pc      = end_pc;
                    wr_data.finished    = 1'b0;
                end
                default: begin
                    need_wr = i_cmd.finish_after;
                    wr_data.entry_value = e_value;
                    wr_data.start_pc    = e_pc;
                    wr_data.end_pc      = e_pc;
                end
            endcase
        end

        step = !i_cmd_empty && (!need_wr || !oq_full);
        wr   = step && need_wr;

        if (step) begin
            if (r_second) begin
                n_second  = 1'b0;
                o_cmd_pop = 1'b1;
            end else if (i_cmd.kind == CMD_PC && i_cmd.finish_after) begin
                n_second = 1'b1;
            end else begin
                o_cmd_pop = 1'b1;
            end
        end
    end

    // Decoder running state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value  <= VALUE_INIT;
            r_pc     <= '0;
            r_second <= 1'b0;
        end else if (step) begin
            r_value  <= n_value;
            r_pc     <= n_pc;
            r_second <= n_second;
        end
    end

    // Result queue occupancy.
    always_comb begin
        n_cnt = r_cnt;
        if (wr && !oq_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (oq_pop && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (oq_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_oq[r_wp] <= wr_data;
        end
    end

endmodule

>>> design/pc_value_table_decoder_unit.sv
// Top level of the pc-value table decoder; instantiates the front end,
// the command queue and the back end. Depends on pcvt_pkg and the assert header.
//
// Decodes an encoded pc-value table fed one byte per word and delivers one
// entry word (value, start pc, end pc) per completed pair, plus a finished
// word when a zero value delta or the last byte ends the table. A byte is
// accepted every cycle while the four-deep command queue has room; a command
// that writes a word waits in the back end for room in the result queue, and a
// pc entry that closes on the table's last byte takes a second step because
// it yields two words. Results leave through a four-deep queue, one per cycle.
// pc_scale may only be written while the block holds no work.
module pc_value_table_decoder_unit
    import pcvt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_in_word   i_word,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_empty,
    output t_out_word  o_result,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data
);

`include "pc_value_table_decoder_unit_assert.svh"

    logic         r_pc_scale;
    logic [3:0]   r_scale;
    logic         cmd_push, cmd_pop, cmd_empty;
    t_cmd         cmd_in, cmd_head;
    t_back_status back_status;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_INIT;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_data;
        end
    end

    // Marks that the scale register has been written at least once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc_scale <= 1'b0;
        end else if (i_cfg_we) begin
            r_pc_scale <= 1'b1;
        end
    end

    pcvt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_word     (i_word),
        .i_cmd_full (o_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    pcvt_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (o_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_head  (cmd_head)
    );

    pcvt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pc_scale  (r_scale),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (o_result),
        .o_status    (back_status)
    );

    // A finished word always reports an empty pc range.
    `PCVT_ASSERT_IMPL(a_fin_range, i_clk, i_rst_n, !o_empty && o_result.finished, o_result.start_pc == o_result.end_pc, "finished word with nonempty range")
    // The second step of a command only exists while that command is queued.
    `PCVT_ASSERT_IMPL(a_second_has_cmd, i_clk, i_rst_n, back_status.second, !cmd_empty, "second step without a command")
    // With room in the result queue the second step completes at once.
    `PCVT_ASSERT_NEXT(a_second_done, i_clk, i_rst_n, back_status.second && !back_status.outq_full, !back_status.second, "second step did not complete")
    // Until the first configuration write the scale keeps its reset value.
    `PCVT_ASSERT_IMPL(a_scale_reset, i_clk, i_rst_n, !r_pc_scale, r_scale == SCALE_INIT, "scale changed without a write")

endmodule
